// ===== design/clcd_pkg.sv =====
`default_nettype none

package clcd_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_CHAR   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_NUM_LINES = 2'd0,
        REG_TALL_FONT = 2'd1
    } reg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    localparam int STEP_W = 4;

    // final step of a begin run and of a single byte run
    localparam logic [STEP_W-1:0] BEGIN_LAST_STEP = 4'd12;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;

    localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
    localparam logic [15:0] WAIT_SETTLE   = 16'd100;
    localparam logic [15:0] WAIT_WAKE_LONG  = 16'd4600;
    localparam logic [15:0] WAIT_WAKE_SHORT = 16'd250;
    localparam logic [15:0] WAIT_CLEAR    = 16'd2100;

    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam logic [7:0] BYTE_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] BYTE_CLEAR      = 8'h01;
    localparam logic [7:0] BYTE_ENTRY_MODE = 8'h06;
    localparam logic [7:0] BYTE_FUNC_BASE  = 8'h20;
    localparam logic [7:0] FUNC_TWO_LINE   = 8'h08;
    localparam logic [7:0] FUNC_TALL_FONT  = 8'h04;
    localparam logic [7:0] BYTE_SET_ADDR   = 8'h80;

    localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    typedef struct packed {
        logic              load;
        logic              emit;
        logic              is_begin;
        logic              is_last;
        logic [STEP_W-1:0] step;
    } dp_ctrl_t;

endpackage

`default_nettype wire

// ===== design/clcd_ctrl.sv =====
`default_nettype none

module clcd_ctrl
    import clcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] cmd,
    output logic            busy,
    output dp_ctrl_t        ctrl
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              begin_reg, begin_next;
    logic              accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            begin_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            begin_reg <= begin_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        begin_next    = begin_reg;
        ctrl.load     = 1'b0;
        ctrl.emit     = 1'b0;
        ctrl.is_begin = begin_reg;
        ctrl.step     = step_reg;
        ctrl.is_last  = begin_reg ? (step_reg == BEGIN_LAST_STEP)
                                  : (step_reg == BYTE_LAST_STEP);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd != CMD_NONE))
                begin
                    ctrl.load  = 1'b1;
                    begin_next = (cmd == CMD_BEGIN);
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctrl.emit = 1'b1;
                if (ctrl.is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/clcd_dp.sv =====
`default_nettype none

module clcd_dp
    import clcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic [5:0]  column,
    input  wire logic [1:0]  row,
    input  dp_ctrl_t         ctrl,
    output logic             strobe,
    output logic             register_select,
    output logic [3:0]       nibble,
    output logic             pulse,
    output logic [15:0]      wait_us,
    output logic             last
);

    logic [2:0]  num_lines_reg;
    logic        tall_font_reg;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  func_reg, func_next;
    logic        rs_reg, rs_next;

    logic        strobe_reg;
    logic        rs_out_reg, rs_out_next;
    logic [3:0]  nib_reg, nib_next;
    logic        pulse_reg, pulse_next;
    logic [15:0] wait_reg, wait_next;
    logic        last_reg;

    logic [1:0]        row_clamped;
    logic [2:0]        lines_m1;
    logic [7:0]        addr_sum;
    logic [7:0]        cur_byte;
    logic [STEP_W-1:0] step_ahead;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lines_reg <= 3'd1;
            tall_font_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NUM_LINES: num_lines_reg <= cfg_data;
                REG_TALL_FONT: tall_font_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // row clamp and DDRAM address for set cursor
    assign lines_m1 = num_lines_reg - 3'd1;
    always_comb
    begin
        if (num_lines_reg == 3'd0)
            row_clamped = 2'd0;
        else if ({1'b0, row} >= num_lines_reg)
            row_clamped = lines_m1[1:0];
        else
            row_clamped = row;
    end
    assign addr_sum = {2'b00, column} + {1'b0, ROW_BASE[row_clamped]};

    always_comb
    begin
        func_next = BYTE_FUNC_BASE;
        if (num_lines_reg > 3'd1)
            func_next = func_next | FUNC_TWO_LINE;
        if (tall_font_reg && (num_lines_reg == 3'd1))
            func_next = func_next | FUNC_TALL_FONT;
        byte_next = (cmd == CMD_CHAR) ? char_code : (BYTE_SET_ADDR | {1'b0, addr_sum[6:0]});
        rs_next   = (cmd == CMD_CHAR);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            func_reg <= func_next;
            byte_reg <= byte_next;
            rs_reg   <= rs_next;
        end
    end

    // byte pairs of a begin run sit on steps 5-6, 7-8, 9-10 and 11-12
    assign step_ahead = ctrl.step + 4'd1;

    // byte being sent at this step of a begin run
    always_comb
    begin
        case (step_ahead[3:1])
            3'd3:    cur_byte = func_reg;
            3'd4:    cur_byte = BYTE_DISPLAY_ON;
            3'd5:    cur_byte = BYTE_CLEAR;
            default: cur_byte = BYTE_ENTRY_MODE;
        endcase
    end

    always_comb
    begin
        rs_out_next = 1'b0;
        pulse_next  = 1'b1;
        wait_next   = WAIT_SETTLE;
        nib_next    = 4'h0;
        if (ctrl.is_begin)
        begin
            case (ctrl.step)
                4'd0:
                begin
                    pulse_next = 1'b0;
                    wait_next  = WAIT_POWER_UP;
                end
                4'd1, 4'd2:
                begin
                    nib_next  = NIB_WAKE;
                    wait_next = WAIT_WAKE_LONG;
                end
                4'd3:
                begin
                    nib_next  = NIB_WAKE;
                    wait_next = WAIT_WAKE_SHORT;
                end
                4'd4:
                begin
                    nib_next = NIB_4BIT;
                end
                default:
                begin
                    // odd steps carry the high nibble, even steps the low one
                    nib_next = ctrl.step[0] ? cur_byte[7:4] : cur_byte[3:0];
                    if (ctrl.step == 4'd10)
                        wait_next = WAIT_CLEAR;
                end
            endcase
        end
        else
        begin
            rs_out_next = rs_reg;
            nib_next    = ctrl.step[0] ? byte_reg[3:0] : byte_reg[7:4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= ctrl.emit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            rs_out_reg <= rs_out_next;
            nib_reg    <= nib_next;
            pulse_reg  <= pulse_next;
            wait_reg   <= wait_next;
            last_reg   <= ctrl.is_last;
        end
    end

    assign strobe          = strobe_reg;
    assign register_select = rs_out_reg;
    assign nibble          = nib_reg;
    assign pulse           = pulse_reg;
    assign wait_us         = wait_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

// ===== design/char_lcd_nibble_sequencer.sv =====
`default_nettype none

// Character LCD 4-bit bus sequencer. A request is taken when start is high
// and busy is low; it then produces one bus write per clock cycle, each shown
// for a single cycle with strobe high, and the receiver must take it then.
// Begin gives 13 writes, set cursor and write character give 2 each; the
// final write carries last. The control state machine steps through the
// writes of an item and holds busy high up to its final step, and the next
// item may start as its last write shows. cmd 3 is taken and gives nothing.
// Configuration writes are always ready.
module char_lcd_nibble_sequencer
    import clcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic [5:0]  column,
    input  wire logic [1:0]  row,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    output logic             strobe,
    output logic             register_select,
    output logic [3:0]       nibble,
    output logic             pulse,
    output logic [15:0]      wait_us,
    output logic             last
);

    dp_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    clcd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    clcd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .char_code       (char_code),
        .column          (column),
        .row             (row),
        .ctrl            (ctrl),
        .strobe          (strobe),
        .register_select (register_select),
        .nibble          (nibble),
        .pulse           (pulse),
        .wait_us         (wait_us),
        .last            (last)
    );

endmodule

`default_nettype wire
